### sv/dce_pkg.sv
`timescale 1ns / 1ps
package dce_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int LBL_W      = 7;
   localparam int MIN_W      = 7;
   localparam int RADIUS_W   = 16;
   localparam int R2_W       = 2 * RADIUS_W;
   localparam int SQ_W       = 2 * COORD_BITS;
   localparam int SUM_W      = SQ_W + 2;
   localparam int CMP_W      = (SUM_W > R2_W) ? SUM_W : R2_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [LBL_W-1:0] LBL_NOISE = LBL_W'(0);
   localparam logic [LBL_W-1:0] LBL_UNCL  = LBL_W'(127);

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POINTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_Z      = 2'd2;

   typedef logic [1:0] op_type;
   localparam op_type OP_COUNT  = 2'd0;
   localparam op_type OP_SEED   = 2'd1;
   localparam op_type OP_EXPAND = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } coord_type;

   typedef struct packed {
      logic             valid;
      op_type           op;
      logic [LBL_W-1:0] id;
      coord_type        pt;
   } token_type;

   typedef struct packed {
      logic             hit;
      logic             push;
      logic [IDX_W-1:0] idx;
   } cell_res_type;

   typedef struct packed {
      logic             clr_all;
      logic             noise_en;
      logic [IDX_W-1:0] noise_idx;
      logic             flush;
   } lbl_cmd_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      coord_type        pt;
   } load_type;

endpackage

### sv/dce_cell.sv
`timescale 1ns / 1ps
module dce_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [dce_pkg::IDX_W-1:0]    cell_idx,
   input  dce_pkg::load_type            load,
   input  dce_pkg::lbl_cmd_type         lbl_cmd,
   input  dce_pkg::token_type           tok_up,
   input  logic                         use_z,
   input  logic [dce_pkg::R2_W-1:0]     radius_sq,
   output dce_pkg::token_type           tok_dn,
   output dce_pkg::cell_res_type        res,
   output dce_pkg::coord_type           point,
   output logic [dce_pkg::LBL_W-1:0]    label
);
   import dce_pkg::*;

   coord_type        point_ff;
   logic             used_ff;
   logic             used_in;
   logic [LBL_W-1:0] label_ff;
   logic [LBL_W-1:0] label_in;
   logic [SQ_W-1:0]  sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SQ_W-1:0]  sq_x_in, sq_y_in, sq_z_in;
   token_type        tok_ff;
   logic [SUM_W-1:0] sum;
   logic             hit;
   logic             push;

   function automatic logic [COORD_BITS-1:0] abs_diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic signed [COORD_BITS:0] d;
      begin
         d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
         if (d[COORD_BITS]) begin
            d = -d;
         end
         return d[COORD_BITS-1:0];
      end
   endfunction

   always_comb begin
      sq_x_in = SQ_W'(abs_diff(tok_up.pt.x, point_ff.x)) * SQ_W'(abs_diff(tok_up.pt.x, point_ff.x));
      sq_y_in = SQ_W'(abs_diff(tok_up.pt.y, point_ff.y)) * SQ_W'(abs_diff(tok_up.pt.y, point_ff.y));
      sq_z_in = SQ_W'(abs_diff(tok_up.pt.z, point_ff.z)) * SQ_W'(abs_diff(tok_up.pt.z, point_ff.z));
   end

   always_comb begin
      sum = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + (use_z ? SUM_W'(sq_z_ff) : '0);
      hit = tok_ff.valid && used_ff && (CMP_W'(sum) <= CMP_W'(radius_sq));
      label_in = label_ff;
      push = 1'b0;
      if (lbl_cmd.clr_all) begin
         label_in = LBL_UNCL;
      end else if (lbl_cmd.noise_en && (lbl_cmd.noise_idx == cell_idx)) begin
         label_in = LBL_NOISE;
      end else if (hit) begin
         unique case (tok_ff.op)
            OP_SEED: begin
               label_in = tok_ff.id;
               push = 1'b1;
            end
            OP_EXPAND: begin
               if (label_ff == LBL_UNCL) begin
                  label_in = tok_ff.id;
                  push = 1'b1;
               end else if (label_ff == LBL_NOISE) begin
                  label_in = tok_ff.id;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      used_in = used_ff;
      if (load.en && (load.idx == cell_idx)) begin
         used_in = 1'b1;
      end else if (lbl_cmd.flush) begin
         used_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         tok_ff <= '0;
      end else begin
         used_ff <= used_in;
         tok_ff <= tok_up;
      end
   end

   always_ff @(posedge clock) begin
      if (load.en && (load.idx == cell_idx)) begin
         point_ff <= load.pt;
      end
      label_ff <= label_in;
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      sq_z_ff <= sq_z_in;
   end

   assign tok_dn   = tok_ff;
   assign res.hit  = hit;
   assign res.push = push;
   assign res.idx  = push ? cell_idx : '0;
   assign point    = point_ff;
   assign label    = label_ff;

endmodule

### sv/dce_ctrl.sv
`timescale 1ns / 1ps
module dce_ctrl (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  logic signed [dce_pkg::COORD_BITS-1:0]         req_x_coord,
   input  logic signed [dce_pkg::COORD_BITS-1:0]         req_y_coord,
   input  logic signed [dce_pkg::COORD_BITS-1:0]         req_z_coord,
   input  logic                                          req_final_point,
   output logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   output logic [dce_pkg::IDX_W-1:0]                     rsp_point_index,
   output logic [dce_pkg::LBL_W-1:0]                     rsp_cluster_label,
   output logic [dce_pkg::LBL_W-1:0]                     rsp_cluster_total,
   output logic                                          rsp_last_label,
   input  logic                                          csr_wr_en,
   input  logic [dce_pkg::CSR_IDX_W-1:0]                 csr_index,
   input  logic [dce_pkg::CSR_DATA_W-1:0]                csr_wdata,
   output dce_pkg::load_type                             load,
   output dce_pkg::lbl_cmd_type                          lbl_cmd,
   output dce_pkg::token_type                            tok_dn,
   output logic                                          use_z,
   output logic [dce_pkg::R2_W-1:0]                      radius_sq,
   input  dce_pkg::cell_res_type [dce_pkg::MAX_POINTS-1:0] res,
   input  dce_pkg::coord_type [dce_pkg::MAX_POINTS-1:0]  points,
   input  logic [dce_pkg::MAX_POINTS-1:0][dce_pkg::LBL_W-1:0] labels,
   input  logic                                          chain_done
);
   import dce_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLEAR  = 4'd1;
   localparam logic [3:0] S_OUTER  = 4'd2;
   localparam logic [3:0] S_ISSUE  = 4'd3;
   localparam logic [3:0] S_WAIT   = 4'd4;
   localparam logic [3:0] S_DECIDE = 4'd5;
   localparam logic [3:0] S_QREAD  = 4'd6;
   localparam logic [3:0] S_QLOAD  = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;
   localparam int CC_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] loaded_ff, loaded_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] outer_ff, outer_in;
   logic [IDX_W-1:0] emit_ff, emit_in;
   logic [IDX_W-1:0] qidx_ff, qidx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] rd_ff;
   logic [LBL_W-1:0] next_cl_ff, next_cl_in;
   logic             start_ff, start_in;
   op_type           op_ff, op_in;
   token_type        tok_ff, tok_in;
   logic [MIN_W-1:0] min_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic             axis_ff;
   logic [R2_W-1:0]  r2_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [LBL_W-1:0] rsp_lbl_ff, rsp_lbl_in;
   logic [LBL_W-1:0] rsp_tot_ff, rsp_tot_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [IDX_W-1:0] queue_mem [MAX_POINTS];
   logic             q_rd_en;
   logic             hit_any;
   logic             push_any;
   logic [IDX_W-1:0] push_idx;
   logic             core;
   logic             accept;
   logic             rsp_free;

   always_comb begin
      hit_any = 1'b0;
      push_any = 1'b0;
      push_idx = '0;
      for (int k = 0; k < MAX_POINTS; k++) begin
         hit_any  = hit_any | res[k].hit;
         push_any = push_any | res[k].push;
         push_idx = push_idx | res[k].idx;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign core      = (CC_W'(count_ff) >= CC_W'(min_ff));

   always_comb begin
      state_in    = state_ff;
      loaded_in   = loaded_ff;
      n_in        = n_ff;
      outer_in    = outer_ff;
      emit_in     = emit_ff;
      qidx_in     = qidx_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      next_cl_in  = next_cl_ff;
      start_in    = start_ff;
      op_in       = op_ff;
      tok_in      = '0;
      q_rd_en     = 1'b0;
      load        = '0;
      lbl_cmd     = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_idx_in  = rsp_idx_ff;
      rsp_lbl_in  = rsp_lbl_ff;
      rsp_tot_in  = rsp_tot_ff;
      rsp_last_in = rsp_last_ff;
      if (push_any) begin
         tail_in = tail_ff + CNT_W'(1);
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (loaded_ff < CNT_W'(MAX_POINTS)) begin
                  load.en   = 1'b1;
                  load.idx  = loaded_ff[IDX_W-1:0];
                  load.pt.x = req_x_coord;
                  load.pt.y = req_y_coord;
                  load.pt.z = req_z_coord;
                  loaded_in = loaded_ff + CNT_W'(1);
               end
               if (req_final_point) begin
                  n_in = loaded_in;
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            lbl_cmd.clr_all = 1'b1;
            next_cl_in = LBL_W'(1);
            outer_in = '0;
            // seed queue starts empty for every run
            head_in = '0;
            tail_in = '0;
            state_in = S_OUTER;
         end
         S_OUTER: begin
            if (outer_ff == n_ff) begin
               emit_in = '0;
               state_in = S_EMIT;
            end else if (labels[outer_ff[IDX_W-1:0]] != LBL_UNCL) begin
               outer_in = outer_ff + CNT_W'(1);
            end else begin
               qidx_in = outer_ff[IDX_W-1:0];
               start_in = 1'b1;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            tok_in.valid = 1'b1;
            tok_in.op    = OP_COUNT;
            tok_in.id    = next_cl_ff;
            tok_in.pt    = points[qidx_ff];
            op_in        = OP_COUNT;
            count_in     = '0;
            state_in     = S_WAIT;
         end
         S_WAIT: begin
            if (op_ff == OP_COUNT) begin
               count_in = count_ff + CNT_W'(hit_any);
            end
            if (chain_done) begin
               state_in = (op_ff == OP_COUNT) ? S_DECIDE : S_QREAD;
            end
         end
         S_DECIDE: begin
            tok_in.id = next_cl_ff;
            tok_in.pt = points[qidx_ff];
            if (start_ff) begin
               if (!core) begin
                  lbl_cmd.noise_en  = 1'b1;
                  lbl_cmd.noise_idx = qidx_ff;
                  outer_in = outer_ff + CNT_W'(1);
                  state_in = S_OUTER;
               end else begin
                  tok_in.valid = 1'b1;
                  tok_in.op    = OP_SEED;
                  op_in        = OP_SEED;
                  head_in      = '0;
                  tail_in      = '0;
                  start_in     = 1'b0;
                  state_in     = S_WAIT;
               end
            end else if (core) begin
               tok_in.valid = 1'b1;
               tok_in.op    = OP_EXPAND;
               op_in        = OP_EXPAND;
               state_in     = S_WAIT;
            end else begin
               state_in = S_QREAD;
            end
         end
         S_QREAD: begin
            if (head_ff == tail_ff) begin
               next_cl_in = next_cl_ff + LBL_W'(1);
               outer_in = outer_ff + CNT_W'(1);
               state_in = S_OUTER;
            end else begin
               q_rd_en = 1'b1;
               head_in = head_ff + CNT_W'(1);
               state_in = S_QLOAD;
            end
         end
         S_QLOAD: begin
            qidx_in = rd_ff;
            start_in = 1'b0;
            state_in = S_ISSUE;
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = emit_ff;
               rsp_lbl_in   = labels[emit_ff];
               rsp_tot_in   = next_cl_ff - LBL_W'(1);
               rsp_last_in  = (CNT_W'(emit_ff) + CNT_W'(1) == n_ff);
               emit_in      = emit_ff + IDX_W'(1);
               if (CNT_W'(emit_ff) + CNT_W'(1) == n_ff) begin
                  lbl_cmd.flush = 1'b1;
                  loaded_in = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loaded_ff    <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         tok_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         next_cl_ff   <= LBL_W'(1);
         min_ff       <= MIN_W'(4);
         radius_ff    <= RADIUS_W'(256);
         axis_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         tok_ff       <= tok_in;
         rsp_valid_ff <= rsp_valid_in;
         next_cl_ff   <= next_cl_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MIN_POINTS: min_ff <= csr_wdata[MIN_W-1:0];
               CSR_RADIUS:     radius_ff <= csr_wdata[RADIUS_W-1:0];
               CSR_USE_Z:      axis_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      outer_ff    <= outer_in;
      emit_ff     <= emit_in;
      qidx_ff     <= qidx_in;
      count_ff    <= count_in;
      start_ff    <= start_in;
      op_ff       <= op_in;
      r2_ff       <= R2_W'(radius_ff) * R2_W'(radius_ff);
      rsp_idx_ff  <= rsp_idx_in;
      rsp_lbl_ff  <= rsp_lbl_in;
      rsp_tot_ff  <= rsp_tot_in;
      rsp_last_ff <= rsp_last_in;
      if (push_any) begin
         queue_mem[tail_ff[IDX_W-1:0]] <= push_idx;
      end
      if (q_rd_en) begin
         rd_ff <= queue_mem[head_ff[IDX_W-1:0]];
      end
   end

   assign tok_dn            = tok_ff;
   assign use_z             = axis_ff;
   assign radius_sq         = r2_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_point_index   = rsp_idx_ff;
   assign rsp_cluster_label = rsp_lbl_ff;
   assign rsp_cluster_total = rsp_tot_ff;
   assign rsp_last_label    = rsp_last_ff;

   // seeds only enter the queue while a token walks the chain
   a_push_in_wait: assert property (@(posedge clock) disable iff (reset)
      push_any |-> (state_ff == S_WAIT))
      else $error("seed push outside wait");

   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("seed queue head passed tail");

   a_tail_le_n: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> (tail_ff <= n_ff))
      else $error("seed queue holds more points than loaded");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("label issued outside emit");

endmodule

### sv/density_clustering_engine_core.sv
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// req_    | in        | req_valid / req_stall | x, y, z coordinates, final_point
// rsp_    | out       | rsp_valid / rsp_stall | point_index, cluster_label, cluster_total, last_label
// csr_    | in        | csr_wr_en             | csr_index, csr_wdata
//
// Loading takes one request per cycle; the final request starts a run and
// req_stall stays high until the last label has been loaded into the output.
// Each neighbor query walks the cell chain; a
// run issues one count query per outer point and per seed, plus one label
// query per core point, then emits one label per cycle unless rsp_stall holds.
// Reset is synchronous and active high; the point store is not cleared.
module density_clustering_engine_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [dce_pkg::COORD_BITS-1:0] req_x_coord,
   input  logic signed [dce_pkg::COORD_BITS-1:0] req_y_coord,
   input  logic signed [dce_pkg::COORD_BITS-1:0] req_z_coord,
   input  logic                                  req_final_point,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [dce_pkg::IDX_W-1:0]             rsp_point_index,
   output logic [dce_pkg::LBL_W-1:0]             rsp_cluster_label,
   output logic [dce_pkg::LBL_W-1:0]             rsp_cluster_total,
   output logic                                  rsp_last_label,
   input  logic                                  csr_wr_en,
   input  logic [dce_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dce_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import dce_pkg::*;

   load_type                       load;
   lbl_cmd_type                    lbl_cmd;
   token_type [MAX_POINTS:0]       link;       // query token hops one cell per cycle
   logic                           use_z;
   logic [R2_W-1:0]                radius_sq;
   cell_res_type [MAX_POINTS-1:0]  res;
   coord_type [MAX_POINTS-1:0]     points;
   logic [MAX_POINTS-1:0][LBL_W-1:0] labels;

   dce_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_x_coord       (req_x_coord),
      .req_y_coord       (req_y_coord),
      .req_z_coord       (req_z_coord),
      .req_final_point   (req_final_point),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_point_index   (rsp_point_index),
      .rsp_cluster_label (rsp_cluster_label),
      .rsp_cluster_total (rsp_cluster_total),
      .rsp_last_label    (rsp_last_label),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .load              (load),
      .lbl_cmd           (lbl_cmd),
      .tok_dn            (link[0]),
      .use_z             (use_z),
      .radius_sq         (radius_sq),
      .res               (res),
      .points            (points),
      .labels            (labels),
      .chain_done        (link[MAX_POINTS].valid)
   );

   // each cell owns one point and its label
   for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
      dce_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(k)),
         .load      (load),
         .lbl_cmd   (lbl_cmd),
         .tok_up    (link[k]),
         .use_z     (use_z),
         .radius_sq (radius_sq),
         .tok_dn    (link[k+1]),
         .res       (res[k]),
         .point     (points[k]),
         .label     (labels[k])
      );
   end

endmodule

### sim/density_clustering_engine_core_tb.sv
`timescale 1ns / 1ps
module density_clustering_engine_core_tb;
   import dce_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;  // unmapped index, write is dropped
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [IDX_W-1:0] index;
      logic [LBL_W-1:0] label;
      logic [LBL_W-1:0] total;
      logic             last;
   } label_rec_type;

   // Label predictor: keeps its own point store and registers, runs the
   // density clustering on each final point and queues the labels it expects.
   class cluster_label_scoreboard;
      longint           px[MAX_POINTS], py[MAX_POINTS], pz[MAX_POINTS];
      int               lbl[MAX_POINTS];
      int               seeds[MAX_POINTS];
      int               n_loaded;
      int               min_pts;
      int               rad;
      bit               use_z;
      int               errors;
      label_rec_type    expected_labels[$];

      function void clear_state();
         n_loaded = 0;
         min_pts  = 4;
         rad      = 256;
         use_z    = 0;
         errors   = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_MIN_POINTS: min_pts = int'(val[MIN_W-1:0]);
            CSR_RADIUS:     rad     = int'(val);
            CSR_USE_Z:      use_z   = val[0];
            default: ;
         endcase
      endfunction

      function bit near(int a, int b);
         longint dx, dy, dz, sum, r2;
         dx  = px[a] - px[b];
         dy  = py[a] - py[b];
         dz  = pz[a] - pz[b];
         sum = dx * dx + dy * dy;
         if (use_z) sum += dz * dz;
         r2  = longint'(rad) * longint'(rad);
         return sum <= r2;
      endfunction

      function int neighbor_count(int p);
         int c;
         c = 0;
         for (int i = 0; i < n_loaded; i++)
            if (near(p, i)) c++;
         return c;
      endfunction

      // Breadth-first growth from one start point; 1 when a cluster formed
      function bit grow_cluster(int start, int id);
         int head, tail, s;
         head = 0;
         tail = 0;
         if (neighbor_count(start) < min_pts) begin
            lbl[start] = int'(LBL_NOISE);
            return 0;
         end
         lbl[start] = id;
         // start point's whole neighborhood joins, relabeled or not
         for (int i = 0; i < n_loaded; i++) begin
            if (near(start, i)) begin
               lbl[i] = id;
               if (tail < MAX_POINTS) seeds[tail++] = i;
            end
         end
         while (head < tail) begin
            s = seeds[head++];
            if (neighbor_count(s) >= min_pts) begin
               for (int i = 0; i < n_loaded; i++) begin
                  if (near(s, i)) begin
                     if (lbl[i] == LBL_UNCL) begin
                        if (tail < MAX_POINTS) seeds[tail++] = i;
                        lbl[i] = id;
                     end else if (lbl[i] == LBL_NOISE) begin
                        lbl[i] = id;
                     end
                  end
               end
            end
         end
         return 1;
      endfunction

      function void note_point(logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y,
                               logic signed [COORD_BITS-1:0] z, logic fin);
         int            next_id;
         label_rec_type r;
         if (n_loaded < MAX_POINTS) begin
            px[n_loaded] = longint'(x);
            py[n_loaded] = longint'(y);
            pz[n_loaded] = longint'(z);
            n_loaded++;
         end
         if (!fin) return;
         next_id = 1;
         for (int i = 0; i < MAX_POINTS; i++) lbl[i] = int'(LBL_UNCL);
         for (int i = 0; i < n_loaded; i++)
            if (lbl[i] == LBL_UNCL)
               if (grow_cluster(i, next_id)) next_id++;
         for (int i = 0; i < n_loaded; i++) begin
            r.index = IDX_W'(i);
            r.label = LBL_W'(lbl[i]);
            r.total = LBL_W'(next_id - 1);
            r.last  = (i + 1 == n_loaded);
            expected_labels = {expected_labels, r};
         end
         n_loaded = 0;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_label(label_rec_type got);
         label_rec_type e;
         if (expected_labels.size() == 0) begin
            report($sformatf("unexpected label for point %0d", got.index));
            return;
         end
         e = expected_labels.pop_front();
         if (got.index !== e.index)
            report($sformatf("point_index %0d, want %0d", got.index, e.index));
         if (got.label !== e.label)
            report($sformatf("point %0d label %0d, want %0d", e.index, got.label, e.label));
         if (got.total !== e.total)
            report($sformatf("point %0d total %0d, want %0d", e.index, got.total, e.total));
         if (got.last !== e.last)
            report($sformatf("point %0d last %0b, want %0b", e.index, got.last, e.last));
      endtask
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic signed [COORD_BITS-1:0] req_x_coord, req_y_coord, req_z_coord;
   logic                         req_final_point;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [IDX_W-1:0]             rsp_point_index;
   logic [LBL_W-1:0]             rsp_cluster_label;
   logic [LBL_W-1:0]             rsp_cluster_total;
   logic                         rsp_last_label;
   logic                         csr_wr_en;
   logic [CSR_IDX_W-1:0]         csr_index;
   logic [CSR_DATA_W-1:0]        csr_wdata;

   cluster_label_scoreboard sb;
   int  cycle_count;
   int  burst_left;
   bit  no_gaps;         // sender runs back to back when set
   int  hold_request;    // cycles of forced receiver hold, picked up below
   int  hold_left;
   int  stall_pct;
   int  pattern_left;
   int  points_sent;

   density_clustering_engine_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL density_clustering_engine_core");
         $finish;
      end
   end

   // Receiver: checks accepted labels and stalls on its own pattern. A long
   // hold requested by the stimulus is counted down here.
   always @(posedge clock) begin
      label_rec_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.index = rsp_point_index;
         got.label = rsp_cluster_label;
         got.total = rsp_cluster_total;
         got.last  = rsp_last_label;
         sb.check_label(got);
      end
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (pattern_left == 0) begin
         pattern_left = $urandom_range(20, 200);
         case ($urandom_range(0, 3))
            0:       stall_pct = 0;    // no stalls for a stretch
            1:       stall_pct = 10;
            2:       stall_pct = 50;
            default: stall_pct = 85;
         endcase
      end
      pattern_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // One request; bursts and gaps are handled here so valid stays high
   // across back-to-back requests.
   task send_point(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
                   logic signed [COORD_BITS-1:0] z, logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_x_coord     <= x;
      req_y_coord     <= y;
      req_z_coord     <= z;
      req_final_point <= fin;
      do @(posedge clock); while (req_stall);
      sb.note_point(x, y, z, fin);
      points_sent++;
   endtask

   // Drop valid and wait until every label is back and the core is idle
   task drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_labels.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   task set_config(int mp, int r, bit z);
      drain();
      write_csr(CSR_MIN_POINTS, CSR_DATA_W'(mp));
      write_csr(CSR_RADIUS, CSR_DATA_W'(r));
      write_csr(CSR_USE_Z, CSR_DATA_W'(z));
   endtask

   // A set of blobs around random centers plus some scattered points
   task send_cluster_set(int n, int spread);
      int cx, cy, cz, dx, dy, dz;
      for (int i = 0; i < n; i++) begin
         if (i % 5 == 0) begin
            cx = $urandom;
            cy = $urandom;
            cz = $urandom;
         end
         if ($urandom_range(0, 99) < 15) begin
            send_point(COORD_BITS'($urandom), COORD_BITS'($urandom),
                       COORD_BITS'($urandom), i == n - 1);
         end else begin
            dx = $urandom_range(0, 2 * spread) - spread;
            dy = $urandom_range(0, 2 * spread) - spread;
            dz = $urandom_range(0, 2 * spread) - spread;
            send_point(COORD_BITS'(cx + dx), COORD_BITS'(cy + dy),
                       COORD_BITS'(cz + dz), i == n - 1);
         end
      end
   endtask

   initial begin
      int r;
      sb = new();
      sb.clear_state();
      cycle_count     = 0;
      burst_left      = 0;
      no_gaps         = 0;
      hold_request    = 0;
      hold_left       = 0;
      stall_pct       = 0;
      pattern_left    = 0;
      points_sent     = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_x_coord     = '0;
      req_y_coord     = '0;
      req_z_coord     = '0;
      req_final_point = 1'b0;
      rsp_stall       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset config, coordinate extremes, a tight group
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
      send_point(-16'sh8000, -16'sh8000, -16'sh8000, 0);
      send_point(0, 0, 0, 0);
      send_point(16, -16, 0, 0);
      send_point(-16, 16, 0, 0);
      send_point(100, 100, 0, 1);
      // single-point set
      send_point(5, 5, 5, 1);

      // 3-D, widest radius, min points at top of field: all noise
      set_config(127, 65535, 1);
      write_csr(CSR_SPARE, 16'h0001);  // must not disturb anything
      send_point(16'sh7fff, -16'sh8000, 0, 0);
      send_point(-16'sh8000, 16'sh7fff, 0, 0);
      send_point(0, 0, 16'sh7fff, 1);

      // zero min points: every point is core; zero radius
      set_config(0, 0, 1);
      send_point(1, 2, 3, 0);
      send_point(1, 2, 3, 0);
      send_point(1, 2, 4, 1);

      // store full: two extra points dropped, run still happens
      set_config(64, 300, 0);
      for (int i = 0; i < MAX_POINTS + 2; i++)
         send_point(COORD_BITS'($urandom_range(0, 15) << 6),
                    COORD_BITS'($urandom_range(0, 15) << 6),
                    COORD_BITS'($urandom), i == MAX_POINTS + 1);

      // Long receiver hold, outlasting the whole run, while the next set
      // queues up behind it
      set_config(3, 400, 0);
      hold_request = 12000;
      send_cluster_set(40, 300);
      send_cluster_set(10, 300);

      // Random sets with configs changing between phases
      while (points_sent < 480) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
               0:       r = 0;
               1:       r = 65535;
               default: r = $urandom_range(16, 2000);
            endcase
            set_config(($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 6), r,
                       1'($urandom_range(0, 1)));
         end
         no_gaps = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 19) == 0)
            send_cluster_set($urandom_range(60, 66), sb.rad + 1);
         else
            send_cluster_set($urandom_range(1, 12), sb.rad + 1);
      end

      drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS density_clustering_engine_core");
      end else begin
         $display("FAIL density_clustering_engine_core");
      end
      $finish;
   end

endmodule
